/* rtl/led_color_effect_generator_macros.svh */
// Assertion macros used by the checker file of the LED color effect generator.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef LED_COLOR_EFFECT_GENERATOR_MACROS_SVH
`define LED_COLOR_EFFECT_GENERATOR_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define LCEG_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("LCEG same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define LCEG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("LCEG next-cycle check failed");

`endif

/* rtl/lceg_pkg.sv */
`default_nettype none

package lceg_pkg;

    // Size of the color table.
    localparam int MAX_COLORS = 4;
    localparam int IDX_W      = 2;
    localparam int COUNT_W    = 3;
    localparam int LEVEL_W    = 8;
    localparam int COLOR_W    = 24;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Largest 8-bit level; also the phase the pulsing effect snaps to.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_BREATH  = 2'd1,
        MODE_RAINBOW = 2'd2,
        MODE_PULSE   = 2'd3
    } lceg_mode_t;

    // Register indexes; the byte address is four times the index.
    typedef enum logic [2:0] {
        REG_EFFECT_MODE = 3'd0,
        REG_STEP_SPEED  = 3'd1,
        REG_COLOR_COUNT = 3'd2,
        REG_COLOR_ZERO  = 3'd3,
        REG_COLOR_ONE   = 3'd4,
        REG_COLOR_TWO   = 3'd5,
        REG_COLOR_THREE = 3'd6
    } lceg_reg_t;

    // Configuration as seen by the effect core.
    typedef struct packed {
        lceg_mode_t                            mode;
        logic [LEVEL_W-1:0]                    speed;
        logic [COUNT_W-1:0]                    count;
        logic [MAX_COLORS-1:0][COLOR_W-1:0]    colors;
    } lceg_cfg_t;

    // Next table index, wrapping at the number of colors in use.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                    input logic [COUNT_W-1:0] used);
        logic [COUNT_W-1:0] inc;
        inc = COUNT_W'(idx) + COUNT_W'(1);
        return (inc >= used) ? '0 : inc[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/lceg_frame_if.sv */
`default_nettype none

// Frame tick channel: one transaction per frame update.
interface lceg_frame_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* rtl/lceg_pixel_if.sv */
`default_nettype none

// Color channel: one HSV color per transaction.
interface lceg_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_hue;
    logic [7:0] out_saturation;
    logic [7:0] out_value;

    modport source (output valid, output out_hue, output out_saturation,
                    output out_value, input ready);
    modport sink (input valid, input out_hue, input out_saturation,
                  input out_value, output ready);
endinterface

`default_nettype wire

/* rtl/led_color_effect_generator.sv */
// LED color effect generator. Each frame tick transaction yields one HSV color transaction,
// in the cycle after the tick is taken; while no color stalls, a new tick can be taken every
// cycle, one tick per clock. The whole effect update is a single pass of 8-bit adds and
// compares into the state registers, and the held color register doubles as the output
// register: a tick is taken whenever the output is empty or being taken in the same cycle.
// Effects and the color table are set over the APB port (registers at byte addresses 0 to
// 24) and should only be written while no ticks are in flight.
`default_nettype none

module led_color_effect_generator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    lceg_frame_if.sink                              frame,
    lceg_pixel_if.source                            pixel,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lceg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lceg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lceg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    lceg_pkg::lceg_cfg_t            cfg;
    logic [lceg_pkg::COLOR_W-1:0]   held_color;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept;

    lceg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lceg_effect_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (accept),
        .restart    (frame.restart),
        .held_color (held_color)
    );

    // Take a tick when the output slot is free or drains this cycle.
    assign frame.ready = !out_valid_reg || pixel.ready;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (pixel.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign pixel.valid          = out_valid_reg;
    assign pixel.out_hue        = held_color[23:16];
    assign pixel.out_saturation = held_color[15:8];
    assign pixel.out_value      = held_color[7:0];

endmodule

`default_nettype wire

/* rtl/lceg_apb_regs.sv */
`default_nettype none

module lceg_apb_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lceg_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [lceg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [lceg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output lceg_pkg::lceg_cfg_t                      cfg
);

    lceg_pkg::lceg_mode_t                                       mode_reg;
    logic [lceg_pkg::LEVEL_W-1:0]                               speed_reg;
    logic [lceg_pkg::COUNT_W-1:0]                               count_reg;
    logic [lceg_pkg::MAX_COLORS-1:0][lceg_pkg::COLOR_W-1:0]     colors_reg;
    lceg_pkg::lceg_reg_t                                        reg_sel;
    logic                                                       wr_en;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign reg_sel = lceg_pkg::lceg_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lceg_pkg::MODE_SOLID;
            speed_reg  <= 8'd1;
            count_reg  <= 3'd1;
            colors_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                lceg_pkg::REG_EFFECT_MODE: mode_reg <= lceg_pkg::lceg_mode_t'(pwdata[1:0]);
                lceg_pkg::REG_STEP_SPEED:  speed_reg <= pwdata[7:0];
                lceg_pkg::REG_COLOR_COUNT: count_reg <= pwdata[2:0];
                lceg_pkg::REG_COLOR_ZERO:  colors_reg[0] <= pwdata[23:0];
                lceg_pkg::REG_COLOR_ONE:   colors_reg[1] <= pwdata[23:0];
                lceg_pkg::REG_COLOR_TWO:   colors_reg[2] <= pwdata[23:0];
                lceg_pkg::REG_COLOR_THREE: colors_reg[3] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_sel)
            lceg_pkg::REG_EFFECT_MODE: prdata = 32'(mode_reg);
            lceg_pkg::REG_STEP_SPEED:  prdata = 32'(speed_reg);
            lceg_pkg::REG_COLOR_COUNT: prdata = 32'(count_reg);
            lceg_pkg::REG_COLOR_ZERO:  prdata = 32'(colors_reg[0]);
            lceg_pkg::REG_COLOR_ONE:   prdata = 32'(colors_reg[1]);
            lceg_pkg::REG_COLOR_TWO:   prdata = 32'(colors_reg[2]);
            lceg_pkg::REG_COLOR_THREE: prdata = 32'(colors_reg[3]);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.speed  = speed_reg;
    assign cfg.count  = count_reg;
    assign cfg.colors = colors_reg;

endmodule

`default_nettype wire

/* rtl/lceg_effect_core.sv */
`default_nettype none

module lceg_effect_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lceg_pkg::lceg_cfg_t              cfg,
    input  wire logic                             step,
    input  wire logic                             restart,
    output logic [lceg_pkg::COLOR_W-1:0]          held_color
);

    localparam int NC = lceg_pkg::MAX_COLORS;
    localparam int LW = lceg_pkg::LEVEL_W;
    localparam int IW = lceg_pkg::IDX_W;
    localparam int CW = lceg_pkg::COUNT_W;

    logic [NC-1:0][LW-1:0]          level_reg, level_next, level_base;
    logic [LW-1:0]                  peak_reg, peak_next, peak_base;
    logic [IW-1:0]                  breath_idx_reg, breath_idx_next;
    logic                           falling_reg, falling_next;
    logic [LW-1:0]                  phase_reg, phase_next;
    logic [IW-1:0]                  pulse_idx_reg, pulse_idx_next;
    logic                           pulse_on_reg, pulse_on_next;
    logic [lceg_pkg::COLOR_W-1:0]   held_reg, held_next;

    logic [CW-1:0]                  used_n;
    logic [IW-1:0]                  idx;
    logic                           fall;
    logic                           on;
    logic [LW-1:0]                  lvl;
    logic [LW:0]                    sum;
    logic [LW-1:0]                  phase;
    logic [lceg_pkg::COLOR_W-1:0]   base;

    // Colors in use, clamped to one through the table size.
    always_comb
    begin
        if (cfg.count == '0)
            used_n = CW'(1);
        else if (cfg.count > CW'(NC))
            used_n = CW'(NC);
        else
            used_n = cfg.count;
    end

    // A restart clears the levels of the colors in use and reloads the peak.
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            level_base[i] = (restart && (CW'(i) < used_n)) ? '0 : level_reg[i];
        end
        peak_base = restart ? cfg.colors[0][LW-1:0] : peak_reg;
    end

    // Per-tick state update for the selected effect.
    always_comb
    begin
        level_next      = level_reg;
        peak_next       = peak_reg;
        breath_idx_next = breath_idx_reg;
        falling_next    = falling_reg;
        phase_next      = phase_reg;
        pulse_idx_next  = pulse_idx_reg;
        pulse_on_next   = pulse_on_reg;
        held_next       = held_reg;
        idx             = '0;
        fall            = 1'b0;
        on              = 1'b0;
        lvl             = '0;
        sum             = '0;
        phase           = '0;
        base            = '0;

        unique case (cfg.mode)
            lceg_pkg::MODE_SOLID:
            begin
                if (restart)
                    held_next = cfg.colors[0];
            end

            lceg_pkg::MODE_BREATH:
            begin
                level_next = level_base;
                peak_next  = peak_base;
                idx        = restart ? '0 : breath_idx_reg;
                fall       = restart ? 1'b0 : falling_reg;
                sum        = {1'b0, level_base[idx]} + {1'b0, cfg.speed};
                // Rise while not yet falling and the step stays under the peak, otherwise fall.
                if ((sum < {1'b0, peak_base}) && !fall)
                    lvl = sum[LW-1:0];
                else
                begin
                    fall = 1'b1;
                    lvl  = level_base[idx] - cfg.speed;
                end
                level_next[idx] = lvl;
                // Near the bottom: start rising again on the next color.
                if (lvl < cfg.speed)
                begin
                    fall = 1'b0;
                    idx  = lceg_pkg::next_index(idx, used_n);
                end
                breath_idx_next = idx;
                falling_next    = fall;
                held_next       = {cfg.colors[idx][lceg_pkg::COLOR_W-1:LW], level_next[idx]};
            end

            lceg_pkg::MODE_RAINBOW:
            begin
                base      = restart ? cfg.colors[0] : held_reg;
                held_next = {base[23:16] + cfg.speed, lceg_pkg::LEVEL_MAX, base[7:0]};
            end

            lceg_pkg::MODE_PULSE:
            begin
                level_next = level_base;
                peak_next  = peak_base;
                idx        = restart ? '0 : pulse_idx_reg;
                on         = restart ? 1'b0 : pulse_on_reg;
                phase      = restart ? '0 : phase_reg;
                sum        = {1'b0, phase} + {1'b0, cfg.speed};
                // Phase overflow toggles the light; turning on moves to the next color.
                if (sum[LW])
                begin
                    phase = lceg_pkg::LEVEL_MAX;
                    if (!on)
                        idx = lceg_pkg::next_index(idx, used_n);
                    on = !on;
                end
                level_next[idx] = on ? peak_base : '0;
                phase_next      = phase + cfg.speed;
                pulse_idx_next  = idx;
                pulse_on_next   = on;
                held_next       = {cfg.colors[idx][lceg_pkg::COLOR_W-1:LW], level_next[idx]};
            end

            default: ;
        endcase
    end

    // State advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            peak_reg       <= '0;
            breath_idx_reg <= '0;
            falling_reg    <= 1'b0;
            phase_reg      <= '0;
            pulse_idx_reg  <= '0;
            pulse_on_reg   <= 1'b0;
            held_reg       <= '0;
        end
        else if (step)
        begin
            level_reg      <= level_next;
            peak_reg       <= peak_next;
            breath_idx_reg <= breath_idx_next;
            falling_reg    <= falling_next;
            phase_reg      <= phase_next;
            pulse_idx_reg  <= pulse_idx_next;
            pulse_on_reg   <= pulse_on_next;
            held_reg       <= held_next;
        end
    end

    assign held_color = held_reg;

endmodule

`default_nettype wire

/* rtl/lceg_checker.sv */
`default_nettype none

`include "led_color_effect_generator_macros.svh"

module lceg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);

    // A stalled color transaction stays offered.
    `LCEG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled output blocks new ticks.
    `LCEG_ASSERT_NOW(a_backpressure, clk, rst_n, out_valid && !out_ready, !in_ready)

    // Every accepted tick produces a color in the next cycle.
    `LCEG_ASSERT_NEXT(a_tick_to_color, clk, rst_n, in_valid && in_ready, out_valid)

    // A drained output with no new tick leaves the channel empty.
    `LCEG_ASSERT_NEXT(a_no_extra, clk, rst_n,
                      out_valid && out_ready && !(in_valid && in_ready), !out_valid)

endmodule

bind led_color_effect_generator lceg_checker u_lceg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready)
);

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One displayed color, field by field.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lceg_pkg::APB_ADDR_W-1:0] paddr;
    logic [lceg_pkg::APB_DATA_W-1:0] pwdata;
    wire  [lceg_pkg::APB_DATA_W-1:0] prdata;
    wire                             pready;

    lceg_frame_if frame_bus ();
    lceg_pixel_if pixel_bus ();

    led_color_effect_generator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_bus),
        .pixel   (pixel_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Register copies as last written.
    lceg_pkg::lceg_mode_t cfg_mode = lceg_pkg::MODE_SOLID;
    logic [7:0]  cfg_speed = 8'd1;
    logic [2:0]  cfg_count = 3'd1;
    logic [23:0] cfg_colors [lceg_pkg::MAX_COLORS] = '{default: 24'h0};

    // Effect state of the color predictor.
    logic [7:0]  level_mem [lceg_pkg::MAX_COLORS] = '{default: 8'h0};
    logic [7:0]  peak_mem = 8'h0;
    logic [1:0]  breath_sel = 2'd0;
    bit          breath_falling = 1'b0;
    logic [7:0]  pulse_acc = 8'h0;
    logic [1:0]  pulse_sel = 2'd0;
    bit          pulse_lit = 1'b0;
    logic [23:0] shown_color = 24'h0;

    hsv_t color_due [$];
    int   mismatch_count = 0;
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;

    // Works out the color that one frame tick leaves on display.
    function automatic hsv_t effect_color(input bit restart_tick);
        int n;
        int idx;
        int v;
        int spd;
        int i;
        spd = int'(cfg_speed);
        n = (cfg_count == 3'd0) ? 1 :
            (int'(cfg_count) > lceg_pkg::MAX_COLORS) ? lceg_pkg::MAX_COLORS :
            int'(cfg_count);
        case (cfg_mode)
            lceg_pkg::MODE_SOLID:
            begin
                if (restart_tick)
                    shown_color = cfg_colors[0];
            end
            lceg_pkg::MODE_BREATH:
            begin
                if (restart_tick)
                begin
                    peak_mem = cfg_colors[0][7:0];
                    for (i = 0; i < n; i++)
                        level_mem[i] = 8'h0;
                    breath_sel = 2'd0;
                    breath_falling = 1'b0;
                end
                idx = int'(breath_sel);
                v = int'(level_mem[idx]);
                // The rise test is done without wrap; the step itself wraps.
                if (v + spd < int'(peak_mem) && !breath_falling)
                    v = (v + spd) & 255;
                else
                begin
                    breath_falling = 1'b1;
                    v = (v - spd) & 255;
                end
                level_mem[idx] = v[7:0];
                if (v < spd)
                begin
                    breath_falling = 1'b0;
                    idx++;
                    if (idx >= n)
                        idx = 0;
                end
                breath_sel = idx[1:0];
                shown_color = {cfg_colors[breath_sel][23:8], level_mem[breath_sel]};
            end
            lceg_pkg::MODE_RAINBOW:
            begin
                if (restart_tick)
                    shown_color = cfg_colors[0];
                shown_color = {shown_color[23:16] + cfg_speed, 8'hFF, shown_color[7:0]};
            end
            default:
            begin
                if (restart_tick)
                begin
                    peak_mem = cfg_colors[0][7:0];
                    for (i = 0; i < n; i++)
                        level_mem[i] = 8'h0;
                    pulse_acc = 8'h0;
                    pulse_sel = 2'd0;
                    pulse_lit = 1'b0;
                end
                idx = int'(pulse_sel);
                // Passing the top of the phase toggles the light; turning on moves on.
                if (int'(pulse_acc) + spd > 255)
                begin
                    pulse_acc = lceg_pkg::LEVEL_MAX;
                    if (!pulse_lit)
                    begin
                        idx++;
                        if (idx >= n)
                            idx = 0;
                    end
                    pulse_lit = !pulse_lit;
                end
                pulse_sel = idx[1:0];
                level_mem[pulse_sel] = pulse_lit ? peak_mem : 8'h0;
                pulse_acc = pulse_acc + cfg_speed;
                shown_color = {cfg_colors[pulse_sel][23:8], level_mem[pulse_sel]};
            end
        endcase
        return hsv_t'(shown_color);
    endfunction

    function automatic void report_mismatch(input string what, input hsv_t due, input hsv_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected h=%02h s=%02h v=%02h, got h=%02h s=%02h v=%02h",
                     $realtime, what, due.hue, due.sat, due.val, got.hue, got.sat, got.val);
    endfunction

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_bus.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            pixel_bus.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            pixel_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Each color transaction is checked against the oldest expected color.
    always @(posedge clk)
    begin : check_pixel
        hsv_t got;
        hsv_t due;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            got = '{pixel_bus.out_hue, pixel_bus.out_saturation, pixel_bus.out_value};
            if (color_due.size() == 0)
                report_mismatch("unexpected color", hsv_t'(24'h0), got);
            else
            begin
                due = color_due.pop_front();
                if (got.hue !== due.hue || got.sat !== due.sat || got.val !== due.val)
                    report_mismatch("color mismatch", due, got);
            end
        end
    end

    // Offers one frame tick and records its expected color once it is taken.
    task automatic send_tick(input bit restart_tick);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(posedge clk);
        end
        frame_bus.valid <= 1'b1;
        frame_bus.restart <= restart_tick;
        @(posedge clk);
        while (!frame_bus.ready)
            @(posedge clk);
        color_due.push_back(effect_color(restart_tick));
    endtask

    // Stops offering ticks and waits until every expected color has arrived.
    task automatic quiesce();
        frame_bus.valid <= 1'b0;
        while (color_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(input lceg_pkg::lceg_reg_t r, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            lceg_pkg::REG_EFFECT_MODE: cfg_mode = lceg_pkg::lceg_mode_t'(d[1:0]);
            lceg_pkg::REG_STEP_SPEED:  cfg_speed = d[7:0];
            lceg_pkg::REG_COLOR_COUNT: cfg_count = d[2:0];
            lceg_pkg::REG_COLOR_ZERO:  cfg_colors[0] = d[23:0];
            lceg_pkg::REG_COLOR_ONE:   cfg_colors[1] = d[23:0];
            lceg_pkg::REG_COLOR_TWO:   cfg_colors[2] = d[23:0];
            lceg_pkg::REG_COLOR_THREE: cfg_colors[3] = d[23:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input lceg_pkg::lceg_mode_t mode, input logic [7:0] speed,
                             input logic [2:0] count, input logic [23:0] c0,
                             input logic [23:0] c1, input logic [23:0] c2,
                             input logic [23:0] c3);
        quiesce();
        apb_write(lceg_pkg::REG_EFFECT_MODE, 32'(mode));
        apb_write(lceg_pkg::REG_STEP_SPEED, 32'(speed));
        apb_write(lceg_pkg::REG_COLOR_COUNT, 32'(count));
        apb_write(lceg_pkg::REG_COLOR_ZERO, 32'(c0));
        apb_write(lceg_pkg::REG_COLOR_ONE, 32'(c1));
        apb_write(lceg_pkg::REG_COLOR_TWO, 32'(c2));
        apb_write(lceg_pkg::REG_COLOR_THREE, 32'(c3));
    endtask

    // Mostly small speeds and in-range counts so that the effects run through
    // their ramps and color changes; extremes and out-of-range counts now and then.
    task automatic random_config();
        logic [7:0]  speed;
        logic [2:0]  count;
        logic [23:0] c0;
        int          pick;
        pick = $urandom_range(9);
        if (pick == 0)
            speed = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
        else if (pick <= 5)
            speed = 8'($urandom_range(16, 1));
        else
            speed = 8'($urandom_range(255));
        count = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
        c0 = 24'($urandom);
        pick = $urandom_range(9);
        if (pick == 0)
            c0[7:0] = 8'h00;
        else if (pick == 1)
            c0[7:0] = 8'hFF;
        configure(lceg_pkg::lceg_mode_t'($urandom_range(3)), speed, count, c0,
                  24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic test_directed_cases();
        // Reset settings, before any restart.
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        // Breathing at full speed, a count of zero acting as one.
        configure(lceg_pkg::MODE_BREATH, 8'd255, 3'd0, 24'hFFFFFF, 24'h000000,
                  24'h80FF7F, 24'h123456);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        // Pulsing at full speed, a count above the table size.
        configure(lceg_pkg::MODE_PULSE, 8'd255, 3'd7, 24'hFFFFFF, 24'h00FF00,
                  24'hFF0001, 24'hABCDEF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        // Rainbow standing still, then with the hue wrapping.
        configure(lceg_pkg::MODE_RAINBOW, 8'd0, 3'd4, 24'h000000, 24'hFFFFFF,
                  24'h000000, 24'hFFFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        quiesce();
        apb_write(lceg_pkg::REG_STEP_SPEED, 32'd255);
        send_tick(1'b0);
        send_tick(1'b0);
        // Mode changes without a restart keep the state.
        quiesce();
        apb_write(lceg_pkg::REG_EFFECT_MODE, 32'(lceg_pkg::MODE_BREATH));
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();
        apb_write(lceg_pkg::REG_EFFECT_MODE, 32'(lceg_pkg::MODE_SOLID));
        send_tick(1'b0);
        send_tick(1'b1);
        // A slow breath up to a low peak across two colors.
        configure(lceg_pkg::MODE_BREATH, 8'd1, 3'd2, 24'h102003, 24'h405060, 24'h0, 24'h0);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
    endtask

    task automatic test_random_effects(input int idle_pct, input int stall, input int n_items);
        int sent;
        int seg_len;
        bit fresh;
        sender_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                quiesce();
                apb_write(lceg_pkg::REG_EFFECT_MODE, 32'($urandom_range(3)));
                fresh = 1'b0;
            end
            else
            begin
                random_config();
                fresh = 1'b1;
            end
            seg_len = $urandom_range(60, 10);
            for (int k = 0; k < seg_len; k++)
                send_tick((k == 0 && fresh) || ($urandom_range(99) < 3));
            sent += seg_len;
        end
    endtask

    // The receiver holds off while ticks keep coming, then the sender pauses
    // until the block has drained.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        configure(lceg_pkg::MODE_PULSE, 8'd37, 3'd3, 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom));
        hold_cycles <= 300;
        for (int k = 0; k < 40; k++)
            send_tick(k == 0);
        quiesce();
        for (int k = 0; k < 20; k++)
            send_tick(1'b0);
    endtask

    initial
    begin
        frame_bus.valid = 1'b0;
        frame_bus.restart = 1'b0;
        pixel_bus.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_effects(0, 0, 380);
        test_random_effects(64, 0, 380);
        test_random_effects(0, 64, 380);
        test_random_effects(22, 22, 380);
        test_backpressure();

        quiesce();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && color_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/lceg_pkg.sv
rtl/lceg_frame_if.sv
rtl/lceg_pixel_if.sv
rtl/lceg_apb_regs.sv
rtl/lceg_effect_core.sv
rtl/led_color_effect_generator.sv
rtl/lceg_checker.sv
bench/tb.sv
